@@ design/atl_pkg.sv @@
package atl_pkg;

  // Fixed field widths on the result stream
  localparam int unsigned VALUE_FIELD_BITS = 31;
  localparam int unsigned POS_FIELD_BITS   = 16;

  // Character codes with a fixed meaning
  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Scanner mode, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_NUMBER = 3'b010,
    MODE_WORD   = 3'b100
  } mode_t;

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_NUMBER  = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_LABEL   = 3'd3,
    KIND_INVALID = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [VALUE_FIELD_BITS-1:0] value;
    logic                        sat;
    logic [POS_FIELD_BITS-1:0]   start;
    logic [POS_FIELD_BITS-1:0]   length;
    logic                        last;
  } result_t;

endpackage

@@ design/assembly_token_lexer.sv @@
// A token is written to the result queue at the transfer of the character that closes it,
//   and is offered on m_axis from the queue head. Throughput: one character per cycle
//   while s_axis_tready is high; a character can yield two tokens, and the output side
//   drains at most one per cycle, so s_axis_tready drops while the 4-entry queue holds > 2.
// Reset (rst, synchronous, active high): scanner goes idle, position 0, queue empty.
module assembly_token_lexer #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned VALUE_BITS    = 31
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  // Token stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [30:0] number_value, [31] value_saturated,
                                      // [47:32] lexeme_start, [63:48] lexeme_length
  output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
  output logic        m_axis_tlast    // last_of_item
);

  localparam int unsigned MAC_BITS   = VALUE_BITS + 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_BITS   = PTR_BITS + 1;
  localparam int unsigned VF         = atl_pkg::VALUE_FIELD_BITS;
  localparam int unsigned PF         = atl_pkg::POS_FIELD_BITS;

  // Character classes, C locale
  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  // Scanner state
  atl_pkg::mode_t            mode, mode_next;
  logic [VALUE_BITS-1:0]     acc, acc_next;
  logic                      ovf, ovf_next;
  logic [POSITION_BITS-1:0]  start, start_next;
  logic [POSITION_BITS-1:0]  len, len_next;
  logic [POSITION_BITS-1:0]  pos, pos_next;

  // Result queue
  atl_pkg::result_t          fifo [FIFO_DEPTH];
  logic [PTR_BITS-1:0]       head, tail;
  logic [CNT_BITS-1:0]       count;

  logic                      accept, pop;
  logic [7:0]                c;
  logic [3:0]                digit;
  logic [MAC_BITS-1:0]       mac;
  logic                      mac_over;
  logic [VALUE_BITS-1:0]     acc_dig;
  logic [POSITION_BITS-1:0]  pos_inc, len_grow;
  logic                      close_v, new_v, done;
  atl_pkg::result_t          r_close, r_new, out0, out1;
  logic                      v0, v1;
  logic [VALUE_BITS+VF-1:0]  acc_ext;
  logic [POSITION_BITS+PF-1:0] start_ext, len_ext, pos_ext;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign c      = s_axis_tdata;
  assign digit  = c[3:0];

  // Times ten plus digit, checked against the value maximum
  assign mac      = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + MAC_BITS'(digit);
  assign mac_over = |mac[MAC_BITS-1:VALUE_BITS];
  assign acc_dig  = mac_over ? {VALUE_BITS{1'b1}} : mac[VALUE_BITS-1:0];

  assign pos_inc  = pos + POSITION_BITS'(1);
  assign len_grow = (&len) ? len : len + POSITION_BITS'(1);

  // Fit internal widths to the fixed result fields
  assign acc_ext   = {{VF{1'b0}}, acc};
  assign start_ext = {{PF{1'b0}}, start};
  assign len_ext   = {{PF{1'b0}}, len};
  assign pos_ext   = {{PF{1'b0}}, pos};

  always_comb begin
    mode_next  = mode;
    acc_next   = acc;
    ovf_next   = ovf;
    start_next = start;
    len_next   = len;
    pos_next   = pos;
    done       = 1'b0;
    close_v    = 1'b0;
    new_v      = 1'b0;

    r_close        = '0;
    r_close.start  = start_ext[PF-1:0];
    r_close.length = len_ext[PF-1:0];
    r_close.kind   = atl_pkg::KIND_IDENT;
    r_new          = '0;
    r_new.start    = pos_ext[PF-1:0];
    r_new.kind     = atl_pkg::KIND_INVALID;

    // Close or extend a pending token
    unique case (mode)
      atl_pkg::MODE_NUMBER: begin
        if (is_digit(c)) begin
          acc_next = acc_dig;
          ovf_next = ovf | mac_over;
          len_next = len_grow;
          pos_next = pos_inc;
          done     = 1'b1;
        end else begin
          close_v       = 1'b1;
          r_close.kind  = atl_pkg::KIND_NUMBER;
          r_close.value = acc_ext[VF-1:0];
          r_close.sat   = ovf;
          mode_next     = atl_pkg::MODE_IDLE;
        end
      end
      atl_pkg::MODE_WORD: begin
        if (is_alpha(c) || is_digit(c)) begin
          len_next = len_grow;
          pos_next = pos_inc;
          done     = 1'b1;
        end else if (c == atl_pkg::CHAR_COLON) begin
          // Label definition swallows the colon
          close_v      = 1'b1;
          r_close.kind = atl_pkg::KIND_LABEL;
          mode_next    = atl_pkg::MODE_IDLE;
          pos_next     = pos_inc;
          done         = 1'b1;
        end else begin
          close_v   = 1'b1;
          mode_next = atl_pkg::MODE_IDLE;
        end
      end
      default: begin
        mode_next = atl_pkg::MODE_IDLE;
      end
    endcase

    // Treat the character on its own
    if (!done) begin
      if (c == atl_pkg::CHAR_END) begin
        new_v      = 1'b1;
        r_new.kind = atl_pkg::KIND_END;
        pos_next   = '0;
        mode_next  = atl_pkg::MODE_IDLE;
      end else if (is_space(c)) begin
        pos_next = pos_inc;
      end else if (is_digit(c)) begin
        mode_next  = atl_pkg::MODE_NUMBER;
        start_next = pos;
        len_next   = POSITION_BITS'(1);
        acc_next   = VALUE_BITS'(digit);
        ovf_next   = 1'b0;
        pos_next   = pos_inc;
      end else if (is_alpha(c)) begin
        mode_next  = atl_pkg::MODE_WORD;
        start_next = pos;
        len_next   = POSITION_BITS'(1);
        acc_next   = '0;
        ovf_next   = 1'b0;
        pos_next   = pos_inc;
      end else begin
        new_v        = 1'b1;
        r_new.kind   = atl_pkg::KIND_INVALID;
        r_new.length = PF'(1);
        pos_next     = pos_inc;
      end
    end

    // Pack into queue slots; the second slot is used only when both fire
    v0        = close_v || new_v;
    v1        = close_v && new_v;
    out0      = close_v ? r_close : r_new;
    out0.last = !v1;
    out1      = r_new;
    out1.last = 1'b1;
  end

  // Scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= atl_pkg::MODE_IDLE;
      pos  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      pos  <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      ovf   <= 1'b0;
      start <= '0;
      len   <= '0;
    end else if (accept) begin
      acc   <= acc_next;
      ovf   <= ovf_next;
      start <= start_next;
      len   <= len_next;
    end
  end

  // Result queue: push up to two entries, pop one
  always_ff @(posedge clk) begin
    if (accept && v0) begin
      fifo[tail] <= out0;
    end
    if (accept && v1) begin
      fifo[tail + PTR_BITS'(1)] <= out1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + PTR_BITS'(1);
      end
      if (accept) begin
        tail <= tail + PTR_BITS'({v1, v0 && !v1});
      end
      count <= count + CNT_BITS'(accept && v0) + CNT_BITS'(accept && v1)
             - CNT_BITS'(pop);
    end
  end

  // Room for the worst case of two tokens from one character
  assign s_axis_tready = (count <= CNT_BITS'(FIFO_DEPTH - 2));
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {fifo[head].length, fifo[head].start, fifo[head].sat,
                          fifo[head].value};
  assign m_axis_tuser  = fifo[head].kind;
  assign m_axis_tlast  = fifo[head].last;

  // Queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // Count tracks pushes and pops
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CNT_BITS'($past(accept && v0))
             + CNT_BITS'($past(accept && v1)) - CNT_BITS'($past(pop)))
    else $error("queue count out of step");

  // A digit keeps a number open
  a_number_holds: assert property (@(posedge clk) disable iff (rst)
    accept && mode == atl_pkg::MODE_NUMBER && is_digit(c) |=> mode == atl_pkg::MODE_NUMBER)
    else $error("number closed by a digit");

  // End of text restarts position and mode
  a_end_restart: assert property (@(posedge clk) disable iff (rst)
    accept && c == atl_pkg::CHAR_END |=> pos == '0 && mode == atl_pkg::MODE_IDLE)
    else $error("end marker did not restart scanner");

  // Two tokens from one character only when a pending token closes
  a_two_needs_close: assert property (@(posedge clk) disable iff (rst)
    accept && v1 |-> mode != atl_pkg::MODE_IDLE)
    else $error("second token without a pending one");

endmodule

@@ dv/testbench.sv @@
module testbench;

  localparam int unsigned VB = atl_pkg::VALUE_FIELD_BITS;
  localparam int unsigned PB = atl_pkg::POS_FIELD_BITS;
  localparam longint unsigned VALUE_MAX = (64'd1 << VB) - 1;
  localparam logic [PB-1:0] LENGTH_MAX = '1;
  localparam int unsigned RANDOM_CHARS = 1120;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Lexer shadow state, advanced once per accepted character
  atl_pkg::mode_t  lex_mode    = atl_pkg::MODE_IDLE;
  logic [VB-1:0]   num_acc     = '0;
  logic            num_clamped = 1'b0;
  logic [PB-1:0]   tok_start   = '0;
  logic [PB-1:0]   tok_len     = '0;
  logic [PB-1:0]   char_pos    = '0;

  // Tokens predicted but not yet seen on the token stream, oldest first
  atl_pkg::result_t pending_tokens[$];

  int  chars_sent    = 0;
  int  tokens_checked = 0;
  int  mismatches    = 0;
  int  clamped_seen  = 0;
  int  kind_seen[5]  = '{default: 0};

  // Idle control: calm flags switch off random gaps, hold_off forces a long stall
  bit  tx_calm  = 1'b0;
  bit  rx_calm  = 1'b0;
  int  hold_off = 0;

  assembly_token_lexer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character classes (C locale)
  // ---------------------------------------------------------------------------
  function automatic bit is_space_char(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit_char(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic bit is_alpha_char(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic [7:0] random_letter();
    return ($urandom_range(0, 1) != 0) ? 8'(65 + $urandom_range(0, 25))
                                      : 8'(97 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'(48 + r);
    if (r < 36) return 8'(65 + r - 10);
    return 8'(97 + r - 36);
  endfunction

  function automatic logic [7:0] random_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------
  function automatic atl_pkg::result_t make_token(atl_pkg::kind_t k, logic [VB-1:0] v,
                                                  logic s, logic [PB-1:0] st,
                                                  logic [PB-1:0] ln);
    atl_pkg::result_t t;
    t.kind   = k;
    t.value  = v;
    t.sat    = s;
    t.start  = st;
    t.length = ln;
    t.last   = 1'b0;
    return t;
  endfunction

  // Multiply by ten and add; clamp at the value maximum and remember it
  task automatic accumulate_digit(input logic [7:0] c);
    longint unsigned d;
    longint unsigned acc;
    d   = 64'(c) - 64'd48;
    acc = 64'(num_acc);
    if (acc > (VALUE_MAX - d) / 10) begin
      num_acc     = '1;
      num_clamped = 1'b1;
    end else begin
      num_acc = VB'(acc * 10 + d);
    end
  endtask

  task automatic open_token(input atl_pkg::mode_t m);
    lex_mode    = m;
    tok_start   = char_pos;
    tok_len     = PB'(1);
    num_acc     = '0;
    num_clamped = 1'b0;
  endtask

  task automatic grow_token();
    if (tok_len != LENGTH_MAX) tok_len++;
  endtask

  // Advance the shadow lexer by one character and queue the tokens it closes
  task automatic lex_char(input logic [7:0] c);
    atl_pkg::result_t toks[$];
    bit               consumed;
    consumed = 1'b0;
    case (lex_mode)
      atl_pkg::MODE_NUMBER: begin
        if (is_digit_char(c)) begin
          accumulate_digit(c);
          grow_token();
          char_pos++;
          consumed = 1'b1;
        end else begin
          toks.push_back(make_token(atl_pkg::KIND_NUMBER, num_acc, num_clamped,
                                    tok_start, tok_len));
          lex_mode = atl_pkg::MODE_IDLE;
        end
      end
      atl_pkg::MODE_WORD: begin
        if (is_alpha_char(c) || is_digit_char(c)) begin
          grow_token();
          char_pos++;
          consumed = 1'b1;
        end else if (c == atl_pkg::CHAR_COLON) begin
          // Label definition swallows its colon
          toks.push_back(make_token(atl_pkg::KIND_LABEL, '0, 1'b0, tok_start, tok_len));
          lex_mode = atl_pkg::MODE_IDLE;
          char_pos++;
          consumed = 1'b1;
        end else begin
          toks.push_back(make_token(atl_pkg::KIND_IDENT, '0, 1'b0, tok_start, tok_len));
          lex_mode = atl_pkg::MODE_IDLE;
        end
      end
      default: lex_mode = atl_pkg::MODE_IDLE;
    endcase
    if (!consumed) begin
      if (c == atl_pkg::CHAR_END) begin
        toks.push_back(make_token(atl_pkg::KIND_END, '0, 1'b0, char_pos, '0));
        char_pos = '0;
        lex_mode = atl_pkg::MODE_IDLE;
      end else if (is_space_char(c)) begin
        char_pos++;
      end else if (is_digit_char(c)) begin
        open_token(atl_pkg::MODE_NUMBER);
        accumulate_digit(c);
        char_pos++;
      end else if (is_alpha_char(c)) begin
        open_token(atl_pkg::MODE_WORD);
        char_pos++;
      end else begin
        toks.push_back(make_token(atl_pkg::KIND_INVALID, '0, 1'b0, char_pos, PB'(1)));
        char_pos++;
      end
    end
    if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
    foreach (toks[i]) pending_tokens.push_back(toks[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: entered and left at a falling edge, tvalid left high
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = 0;
    if (!tx_calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    lex_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // Drop tvalid once a test has nothing more to offer
  task automatic end_input();
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_number();
    longint unsigned v;
    logic [7:0]      digits[$];
    int              r;
    r = $urandom_range(0, 9);
    if (r < 6) v = $urandom_range(0, 9999);
    else if (r < 8) v = VALUE_MAX - 2 + $urandom_range(0, 4);   // around the clamp point
    else v = {$urandom, $urandom} % 64'd1_000_000_000_000_000_000;
    do begin
      digits.push_front(8'(48 + v % 10));
      v = v / 10;
    end while (v != 0);
    if ($urandom_range(0, 7) == 0) digits.push_front(8'd48);
    foreach (digits[i]) send_char(digits[i]);
  endtask

  // One lexeme of random content; neighbors are not separated on purpose
  task automatic send_random_token();
    int         r;
    int         n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_number();
    end else if (r < 60) begin
      send_char(random_letter());
      n = $urandom_range(0, 8);
      repeat (n) send_char(random_alnum());
      if (r >= 48) send_char(atl_pkg::CHAR_COLON);
    end else if (r < 80) begin
      n = $urandom_range(1, 3);
      repeat (n) send_char(random_space());
    end else if (r < 92) begin
      do c = 8'($urandom_range(1, 255));
      while (is_alpha_char(c) || is_digit_char(c) || is_space_char(c));
      send_char(c);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Token side: random ready bursts, or a forced hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : drive_ready
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_axis_tready = 1'b0;
        hold_off--;
      end else if (rx_calm) begin
        m_axis_tready = 1'b1;
      end else if (stall > 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else if ($urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        stall = $urandom_range(0, 15);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch at token %0d: %s got %0d, expected %0d",
             tokens_checked, what, got, want);
  endtask

  // Compare every token transfer against the oldest prediction
  always @(posedge clk) begin : check_tokens
    atl_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      tokens_checked++;
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected token, kind", 64'(m_axis_tuser), 64'd0);
      end else begin
        want = pending_tokens.pop_front();
        if (m_axis_tuser != want.kind)
          report_mismatch("token_kind", 64'(m_axis_tuser), 64'(want.kind));
        if (m_axis_tdata[30:0] != want.value)
          report_mismatch("number_value", 64'(m_axis_tdata[30:0]), 64'(want.value));
        if (m_axis_tdata[31] != want.sat)
          report_mismatch("value_saturated", 64'(m_axis_tdata[31]), 64'(want.sat));
        if (m_axis_tdata[47:32] != want.start)
          report_mismatch("lexeme_start", 64'(m_axis_tdata[47:32]), 64'(want.start));
        if (m_axis_tdata[63:48] != want.length)
          report_mismatch("lexeme_length", 64'(m_axis_tdata[63:48]), 64'(want.length));
        if (m_axis_tlast != want.last)
          report_mismatch("last_of_item", 64'(m_axis_tlast), 64'(want.last));
        kind_seen[int'(want.kind)]++;
        if (want.sat) clamped_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Digits running into letters, a label, a clamped number closed by a non-ASCII
  // byte, punctuation, and a word closed directly by the end marker
  task automatic test_directed_tokens();
    send_string("12ab x:\t2147483648");
    send_char(8'hFF);
    send_string("!");
    send_char(atl_pkg::CHAR_END);
    send_string("y");
    send_char(atl_pkg::CHAR_END);
    end_input();
  endtask

  // Hold the token side off while characters keep coming; each "a!" pair closes
  // two tokens, so the result queue fills and the input must stall
  task automatic test_backpressure();
    tx_calm  = 1'b1;
    hold_off = 400;
    repeat (40) send_string("a!");
    send_char(atl_pkg::CHAR_END);
    end_input();
    tx_calm = 1'b0;
  endtask

  // One long word, then a number closed by a colon that stands on its own
  task automatic test_long_word();
    send_string(" ");
    send_char(random_letter());
    repeat (60) send_char(random_alnum());
    send_string(" 7:");
    send_char(atl_pkg::CHAR_END);
    end_input();
  endtask

  // Random texts of mixed lexemes, each closed by an end marker; idling stops
  // for the final fifth of the run
  task automatic test_random_text(input int budget);
    int first;
    int n;
    first = chars_sent;
    while (chars_sent - first < budget) begin
      if (chars_sent - first > budget * 4 / 5) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      n = $urandom_range(1, 20);
      repeat (n) send_random_token();
      send_char(atl_pkg::CHAR_END);
    end
    end_input();
  endtask

  initial begin : run
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_tokens();
    test_backpressure();
    test_long_word();
    test_random_text(RANDOM_CHARS);

    // Drain, then let the last transfers settle
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d characters and %0d tokens (%0d clamped numbers)",
             chars_sent, tokens_checked, clamped_seen);
    $display("tokens by kind: end %0d, number %0d, identifier %0d, label %0d, invalid %0d",
             kind_seen[int'(atl_pkg::KIND_END)], kind_seen[int'(atl_pkg::KIND_NUMBER)],
             kind_seen[int'(atl_pkg::KIND_IDENT)], kind_seen[int'(atl_pkg::KIND_LABEL)],
             kind_seen[int'(atl_pkg::KIND_INVALID)]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/atl_pkg.sv
design/assembly_token_lexer.sv
dv/testbench.sv
